// File: src/svpd_pkg.sv
`timescale 1ns / 1ps

package svpd_pkg;

    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_sector;

    typedef struct packed {
        logic    valid;
        t_sector sector;
    } t_ctl;

    localparam t_word SQRT3_2 = 32'h6ED9_EBA1;
    localparam t_word HALF    = 32'h4000_0000;
    localparam t_word ONE     = 32'h7FFF_FFFF;
    localparam t_word MAX_VAL = 32'h7FFF_FFFF;
    localparam t_word MIN_VAL = 32'h8000_0000;

    localparam t_sector SECTOR_NONE = 3'd0;
    localparam t_sector SECTOR_1    = 3'd1;
    localparam t_sector SECTOR_2    = 3'd2;
    localparam t_sector SECTOR_3    = 3'd3;
    localparam t_sector SECTOR_4    = 3'd4;
    localparam t_sector SECTOR_5    = 3'd5;
    localparam t_sector SECTOR_6    = 3'd6;
    localparam t_sector SECTOR_ALL  = 3'd7;

    function automatic t_word f_sat(input logic [32:0] v);
        t_word r;
        if (v[32] != v[31]) begin
            r = v[32] ? MIN_VAL : MAX_VAL;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_word f_add(input t_word a, input t_word b);
        return f_sat({a[31], a} + {b[31], b});
    endfunction

    function automatic t_word f_sub(input t_word a, input t_word b);
        return f_sat({a[31], a} - {b[31], b});
    endfunction

    function automatic t_word f_neg(input t_word a);
        t_word r;
        if (a == MIN_VAL) begin
            r = MAX_VAL;
        end else begin
            r = t_word'(~a + 32'd1);
        end
        return r;
    endfunction

    function automatic t_word f_half(input t_word a);
        return {a[31], a[31:1]};
    endfunction

    function automatic logic f_pos(input t_word a);
        return !a[31] && (a != '0);
    endfunction

    function automatic t_word f_duty(input t_word t);
        t_word d;
        d = f_sub(t, HALF);
        return {d[30:0], 1'b0};
    endfunction

endpackage

// File: src/space_vector_pwm_duty.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start, busy (always low)  i_alpha, i_beta (signed Q31)
// result    out        o_done strobe, one cycle  o_duty_a, o_duty_b, o_duty_c (signed Q31)
//
// One vector is taken every clock; each result passes through the registered stages listed below.
// The stages are: alpha multiply, sector and X/Y/Z, on-times in two steps, phase mapping.
// Reset clears only the control bits (valid and sector) and the done flag; no vector is in flight after reset.
// The receiver cannot stall, so results leave the moment they are ready.

module space_vector_pwm_duty (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  svpd_pkg::t_word i_alpha,
    input  svpd_pkg::t_word i_beta,
    output logic            o_done,
    output svpd_pkg::t_word o_duty_a,
    output svpd_pkg::t_word o_duty_b,
    output svpd_pkg::t_word o_duty_c
);
    import svpd_pkg::*;

    logic  w_s1_valid;
    t_word w_s1_p2, w_s1_beta;
    t_ctl  w_s2_ctl;
    t_word w_s2_x, w_s2_y, w_s2_z;
    t_ctl  w_s4_ctl;
    t_word w_s4_first, w_s4_second, w_s4_t2;

    assign busy = 1'b0;

    svpd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_alpha (i_alpha),
        .i_beta  (i_beta),
        .o_valid (w_s1_valid),
        .o_p2    (w_s1_p2),
        .o_beta  (w_s1_beta)
    );

    svpd_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_p2    (w_s1_p2),
        .i_beta  (w_s1_beta),
        .o_ctl   (w_s2_ctl),
        .o_x     (w_s2_x),
        .o_y     (w_s2_y),
        .o_z     (w_s2_z)
    );

    svpd_time u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_s2_ctl),
        .i_x      (w_s2_x),
        .i_y      (w_s2_y),
        .i_z      (w_s2_z),
        .o_ctl    (w_s4_ctl),
        .o_first  (w_s4_first),
        .o_second (w_s4_second),
        .o_t2     (w_s4_t2)
    );

    svpd_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_s4_ctl),
        .i_first  (w_s4_first),
        .i_second (w_s4_second),
        .i_t2     (w_s4_t2),
        .o_done   (o_done),
        .o_duty_a (o_duty_a),
        .o_duty_b (o_duty_b),
        .o_duty_c (o_duty_c)
    );

endmodule

// File: src/svpd_scale.sv
`timescale 1ns / 1ps

module svpd_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  svpd_pkg::t_word i_alpha,
    input  svpd_pkg::t_word i_beta,
    output logic          o_valid,
    output svpd_pkg::t_word o_p2,
    output svpd_pkg::t_word o_beta
);
    import svpd_pkg::*;

    logic signed [63:0] w_prod;
    logic  r_valid;
    t_word r_p2;
    t_word r_beta;
    t_word n_p2;

    always_comb begin
        w_prod = 64'($signed(i_alpha)) * 64'($signed(SQRT3_2));
        n_p2   = w_prod[62:31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2   <= n_p2;
        r_beta <= i_beta;
    end

    assign o_valid = r_valid;
    assign o_p2    = r_p2;
    assign o_beta  = r_beta;

endmodule

// File: src/svpd_sector.sv
`timescale 1ns / 1ps

module svpd_sector (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  svpd_pkg::t_word i_p2,
    input  svpd_pkg::t_word i_beta,
    output svpd_pkg::t_ctl  o_ctl,
    output svpd_pkg::t_word o_x,
    output svpd_pkg::t_word o_y,
    output svpd_pkg::t_word o_z
);
    import svpd_pkg::*;

    t_ctl  r_ctl;
    t_ctl  n_ctl;
    t_word r_x, r_y, r_z;
    t_word n_y, n_z;
    t_word w_p1n, w_p1p, w_vb, w_vc;

    always_comb begin
        w_p1n = f_half(f_neg(i_beta));
        w_vb  = f_add(w_p1n, i_p2);
        w_vc  = f_sub(w_p1n, i_p2);
        w_p1p = f_half(i_beta);
        n_y   = f_add(w_p1p, i_p2);
        n_z   = f_sub(w_p1p, i_p2);
        n_ctl.valid  = i_valid;
        n_ctl.sector = {f_pos(w_vc), f_pos(w_vb), f_pos(i_beta)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_beta;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// File: src/svpd_time.sv
`timescale 1ns / 1ps

module svpd_time (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svpd_pkg::t_ctl  i_ctl,
    input  svpd_pkg::t_word i_x,
    input  svpd_pkg::t_word i_y,
    input  svpd_pkg::t_word i_z,
    output svpd_pkg::t_ctl  o_ctl,
    output svpd_pkg::t_word o_first,
    output svpd_pkg::t_word o_second,
    output svpd_pkg::t_word o_t2
);
    import svpd_pkg::*;

    t_ctl  r_ctl_a, r_ctl_b;
    t_word r_first_a, r_t1, r_t2_a;
    t_word r_first_b, r_second, r_t2_b;
    t_word n_t1, n_t2, n_first, n_second;

    always_comb begin
        case (i_ctl.sector)
            SECTOR_1: begin
                n_t1 = i_z;
                n_t2 = i_y;
            end
            SECTOR_2: begin
                n_t1 = i_y;
                n_t2 = f_neg(i_x);
            end
            SECTOR_3: begin
                n_t1 = f_neg(i_z);
                n_t2 = i_x;
            end
            SECTOR_4: begin
                n_t1 = f_neg(i_x);
                n_t2 = i_z;
            end
            SECTOR_5: begin
                n_t1 = i_x;
                n_t2 = f_neg(i_y);
            end
            SECTOR_6: begin
                n_t1 = f_neg(i_y);
                n_t2 = f_neg(i_z);
            end
            default: begin
                n_t1 = '0;
                n_t2 = '0;
            end
        endcase
        n_first = f_half(f_sub(f_sub(ONE, n_t1), n_t2));
    end

    assign n_second = f_add(r_first_a, r_t1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
        end else begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_a <= n_first;
        r_t1      <= n_t1;
        r_t2_a    <= n_t2;
        r_first_b <= r_first_a;
        r_second  <= n_second;
        r_t2_b    <= r_t2_a;
    end

    assign o_ctl    = r_ctl_b;
    assign o_first  = r_first_b;
    assign o_second = r_second;
    assign o_t2     = r_t2_b;

endmodule

// File: src/svpd_out.sv
`timescale 1ns / 1ps

module svpd_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  svpd_pkg::t_ctl  i_ctl,
    input  svpd_pkg::t_word i_first,
    input  svpd_pkg::t_word i_second,
    input  svpd_pkg::t_word i_t2,
    output logic            o_done,
    output svpd_pkg::t_word o_duty_a,
    output svpd_pkg::t_word o_duty_b,
    output svpd_pkg::t_word o_duty_c
);
    import svpd_pkg::*;

    logic  r_done;
    t_word r_duty_a, r_duty_b, r_duty_c;
    t_word w_third, w_ta, w_tb, w_tc;

    always_comb begin
        w_third = f_add(i_second, i_t2);
        case (i_ctl.sector)
            SECTOR_1: begin
                w_ta = i_second;
                w_tb = i_first;
                w_tc = w_third;
            end
            SECTOR_2: begin
                w_ta = i_first;
                w_tb = w_third;
                w_tc = i_second;
            end
            SECTOR_3: begin
                w_ta = i_first;
                w_tb = i_second;
                w_tc = w_third;
            end
            SECTOR_4: begin
                w_ta = w_third;
                w_tb = i_second;
                w_tc = i_first;
            end
            SECTOR_5: begin
                w_ta = w_third;
                w_tb = i_first;
                w_tc = i_second;
            end
            SECTOR_6: begin
                w_ta = i_second;
                w_tb = w_third;
                w_tc = i_first;
            end
            default: begin
                w_ta = HALF;
                w_tb = HALF;
                w_tc = HALF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty_a <= f_duty(w_ta);
        r_duty_b <= f_duty(w_tb);
        r_duty_c <= f_duty(w_tc);
    end

    assign o_done   = r_done;
    assign o_duty_a = r_duty_a;
    assign o_duty_b = r_duty_b;
    assign o_duty_c = r_duty_c;

endmodule
